// ===== rtl/s2c_pkg.sv =====
`default_nettype none

package s2c_pkg;

    // CORDIC iteration count and datapath width
    localparam int CORDIC_N = 30;
    localparam int CW       = 34;

    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [CW-1:0] TRIG_ONE  = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [31:0]   QUARTER   = 32'sd1073741824;

    // Arctangent of 2^-i in binary-angle units
    localparam logic [29:0] ATAN_TAB [CORDIC_N] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    // Operands that ride along the CORDIC stages
    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] td;
        logic signed [31:0] pd;
        logic signed [31:0] rd;
    } carry_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [47:0] vel_x;
        logic signed [47:0] vel_y;
        logic signed [47:0] vel_z;
    } result_t;

    // Round half up, then arithmetic shift right by s
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] p,
                                                   input int s);
        logic signed [71:0] bias;
        bias = 72'sd1 <<< (s - 1);
        return (p + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi) return 32'sh7FFFFFFF;
        else if (v < lo) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd140737488355327;
        lo = -72'sd140737488355328;
        if (v > hi) return 48'sh7FFFFFFFFFFF;
        else if (v < lo) return 48'sh800000000000;
        else return v[47:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spherical_to_cartesian_pos_vel.sv =====
`default_nettype none
// Spherical to Cartesian conversion of a position and its rates.
// Input channel (s_valid/s_ready): longitude, latitude (binary angles, 2^31 = pi),
// radius (Q16.16), longitude_rate, latitude_rate (Q4.28 rad per time unit),
// radius_rate (Q16.16). Result channel (m_valid/m_ready): pos_x/y/z (Q16.16,
// saturated) and vel_x/y/z (Q32.16, saturated). One result per transaction.
// Throughput: one transaction per cycle while the skid buffer is empty; the
// 30-stage CORDIC (one iteration per stage, two angle lanes) and the five
// product and rounding stages M1 to M5 are fully pipelined.
// Every stage advances on a common enable. When the receiver stalls, results
// keep flowing into the output register and then into a one-entry skid
// buffer; only once the skid buffer holds a result does s_ready drop and the
// pipeline freeze, so nothing is lost or repeated.
// Reset (aresetn, synchronous, active low) clears every valid bit and the skid
// buffer; in-flight transactions are dropped. No clearing pass is needed.
module spherical_to_cartesian_pos_vel
    import s2c_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_longitude,
    input  wire logic signed [31:0] s_latitude,
    input  wire logic signed [31:0] s_radius,
    input  wire logic signed [31:0] s_longitude_rate,
    input  wire logic signed [31:0] s_latitude_rate,
    input  wire logic signed [31:0] s_radius_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic signed [31:0]      m_pos_z,
    output logic signed [47:0]      m_vel_x,
    output logic signed [47:0]      m_vel_y,
    output logic signed [47:0]      m_vel_z
);

    logic en;

    // CORDIC lanes: 0 is longitude, 1 is latitude
    logic signed [CW-1:0] cx_reg   [2][CORDIC_N+1];
    logic signed [CW-1:0] cy_reg   [2][CORDIC_N+1];
    logic signed [CW-1:0] cz_reg   [2][CORDIC_N+1];
    logic                 flip_reg [2][CORDIC_N+1];
    carry_t               car_reg  [CORDIC_N+1];
    logic                 cv_reg   [CORDIC_N+1];

    logic signed [CW-1:0] ang_ext [2];
    logic signed [31:0]   ang_in  [2];
    logic signed [CW-1:0] z_fold  [2];
    logic                 flip_in [2];

    assign ang_in[0] = s_longitude;
    assign ang_in[1] = s_latitude;

    // Fold angles into [-pi/2, pi/2]
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            ang_ext[l] = CW'(ang_in[l]);
            if (ang_in[l] > QUARTER) begin
                z_fold[l]  = ang_ext[l] - HALF_TURN;
                flip_in[l] = 1'b1;
            end else if (ang_in[l] < -QUARTER) begin
                z_fold[l]  = ang_ext[l] + HALF_TURN;
                flip_in[l] = 1'b1;
            end else begin
                z_fold[l]  = ang_ext[l];
                flip_in[l] = 1'b0;
            end
        end
    end

    // Load the first CORDIC stage of each lane
    for (genvar l = 0; l < 2; l++) begin : g_load
        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[l][0]   <= CORDIC_K;
                cy_reg[l][0]   <= '0;
                cz_reg[l][0]   <= z_fold[l];
                flip_reg[l][0] <= flip_in[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_reg[0] <= '{r: s_radius, td: s_longitude_rate,
                            pd: s_latitude_rate, rd: s_radius_rate};
        end
    end

    // One CORDIC iteration per stage
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
        logic signed [CW-1:0] atan_val;
        assign atan_val = signed'({{(CW-30){1'b0}}, ATAN_TAB[i]});
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!cz_reg[l][i][CW-1]) begin
                        cx_reg[l][i+1] <= cx_reg[l][i] - (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] + (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] - atan_val;
                    end else begin
                        cx_reg[l][i+1] <= cx_reg[l][i] + (cy_reg[l][i] >>> i);
                        cy_reg[l][i+1] <= cy_reg[l][i] - (cx_reg[l][i] >>> i);
                        cz_reg[l][i+1] <= cz_reg[l][i] + atan_val;
                    end
                    flip_reg[l][i+1] <= flip_reg[l][i];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                car_reg[i+1] <= car_reg[i];
            end
        end
    end

    // Unfold and clamp to [-1, 1]
    logic signed [CW-1:0] cos_f [2];
    logic signed [CW-1:0] sin_f [2];
    logic signed [31:0]   cos_c [2];
    logic signed [31:0]   sin_c [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cos_f[l] = flip_reg[l][CORDIC_N] ? -cx_reg[l][CORDIC_N] : cx_reg[l][CORDIC_N];
            sin_f[l] = flip_reg[l][CORDIC_N] ? -cy_reg[l][CORDIC_N] : cy_reg[l][CORDIC_N];
            if (cos_f[l] > TRIG_ONE) cos_c[l] = 32'(TRIG_ONE);
            else if (cos_f[l] < -TRIG_ONE) cos_c[l] = 32'(-TRIG_ONE);
            else cos_c[l] = cos_f[l][31:0];
            if (sin_f[l] > TRIG_ONE) sin_c[l] = 32'(TRIG_ONE);
            else if (sin_f[l] < -TRIG_ONE) sin_c[l] = 32'(-TRIG_ONE);
            else sin_c[l] = sin_f[l][31:0];
        end
    end

    logic signed [31:0] t_ct_reg, t_st_reg, t_cp_reg, t_sp_reg;
    carry_t             t_car_reg;
    logic               tv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_ct_reg  <= cos_c[0];
            t_st_reg  <= sin_c[0];
            t_cp_reg  <= cos_c[1];
            t_sp_reg  <= sin_c[1];
            t_car_reg <= car_reg[CORDIC_N];
        end
    end

    // Stage M1: first products
    logic signed [63:0] m1_rcp_reg, m1_z_reg, m1_rpd_reg, m1_crd_reg, m1_srd_reg;
    logic signed [31:0] m1_ct_reg, m1_st_reg, m1_cp_reg, m1_sp_reg, m1_td_reg;
    logic               m1v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_rcp_reg <= t_car_reg.r * t_cp_reg;
            m1_z_reg   <= t_car_reg.r * t_sp_reg;
            m1_rpd_reg <= t_car_reg.r * t_car_reg.pd;
            m1_crd_reg <= t_cp_reg * t_car_reg.rd;
            m1_srd_reg <= t_sp_reg * t_car_reg.rd;
            m1_ct_reg  <= t_ct_reg;
            m1_st_reg  <= t_st_reg;
            m1_cp_reg  <= t_cp_reg;
            m1_sp_reg  <= t_sp_reg;
            m1_td_reg  <= t_car_reg.td;
        end
    end

    // Stage M2: round and scale
    logic signed [32:0] m2_rcp_reg, m2_z_reg;
    logic signed [35:0] m2_rpd_reg;
    logic signed [33:0] m2_crd_reg, m2_srd_reg;
    logic signed [31:0] m2_ct_reg, m2_st_reg, m2_cp_reg, m2_sp_reg, m2_td_reg;
    logic               m2v_reg;
    logic signed [71:0] m2_rcp_next, m2_z_next, m2_rpd_next, m2_crd_next, m2_srd_next;

    always_comb begin
        m2_rcp_next = rnd_shr(72'(m1_rcp_reg), 30);
        m2_z_next   = rnd_shr(72'(m1_z_reg), 30);
        m2_rpd_next = rnd_shr(72'(m1_rpd_reg), 28);
        m2_crd_next = rnd_shr(72'(m1_crd_reg), 30);
        m2_srd_next = rnd_shr(72'(m1_srd_reg), 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_rcp_reg <= m2_rcp_next[32:0];
            m2_z_reg   <= m2_z_next[32:0];
            m2_rpd_reg <= m2_rpd_next[35:0];
            m2_crd_reg <= m2_crd_next[33:0];
            m2_srd_reg <= m2_srd_next[33:0];
            m2_ct_reg  <= m1_ct_reg;
            m2_st_reg  <= m1_st_reg;
            m2_cp_reg  <= m1_cp_reg;
            m2_sp_reg  <= m1_sp_reg;
            m2_td_reg  <= m1_td_reg;
        end
    end

    // Stage M3: second products
    logic signed [64:0] m3_x_reg, m3_y_reg;
    logic signed [67:0] m3_rps_reg, m3_rpc_reg;
    logic signed [32:0] m3_z_reg;
    logic signed [33:0] m3_crd_reg, m3_srd_reg;
    logic signed [31:0] m3_ct_reg, m3_st_reg, m3_td_reg;
    logic               m3v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m3_x_reg   <= 65'(m2_rcp_reg) * 65'(m2_ct_reg);
            m3_y_reg   <= 65'(m2_rcp_reg) * 65'(m2_st_reg);
            m3_rps_reg <= 68'(m2_rpd_reg) * 68'(m2_sp_reg);
            m3_rpc_reg <= 68'(m2_rpd_reg) * 68'(m2_cp_reg);
            m3_z_reg   <= m2_z_reg;
            m3_crd_reg <= m2_crd_reg;
            m3_srd_reg <= m2_srd_reg;
            m3_ct_reg  <= m2_ct_reg;
            m3_st_reg  <= m2_st_reg;
            m3_td_reg  <= m2_td_reg;
        end
    end

    // Stage M4: round, form x, y, w and vz
    logic signed [71:0] m4_x_next, m4_y_next, m4_w_next, m4_vz_next;
    logic signed [34:0] m4_x_reg, m4_y_reg;
    logic signed [37:0] m4_w_reg, m4_vz_reg;
    logic signed [32:0] m4_z_reg;
    logic signed [31:0] m4_ct_reg, m4_st_reg, m4_td_reg;
    logic               m4v_reg;

    always_comb begin
        m4_x_next  = rnd_shr(72'(m3_x_reg), 30);
        m4_y_next  = rnd_shr(72'(m3_y_reg), 30);
        m4_w_next  = rnd_shr(72'(m3_rps_reg), 30) - 72'(m3_crd_reg);
        m4_vz_next = rnd_shr(72'(m3_rpc_reg), 30) + 72'(m3_srd_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_x_reg  <= m4_x_next[34:0];
            m4_y_reg  <= m4_y_next[34:0];
            m4_w_reg  <= m4_w_next[37:0];
            m4_vz_reg <= m4_vz_next[37:0];
            m4_z_reg  <= m3_z_reg;
            m4_ct_reg <= m3_ct_reg;
            m4_st_reg <= m3_st_reg;
            m4_td_reg <= m3_td_reg;
        end
    end

    // Stage M5: velocity products
    logic signed [66:0] m5_ytd_reg, m5_xtd_reg;
    logic signed [69:0] m5_wct_reg, m5_wst_reg;
    logic signed [34:0] m5_x_reg, m5_y_reg;
    logic signed [32:0] m5_z_reg;
    logic signed [37:0] m5_vz_reg;
    logic               m5v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m5_ytd_reg <= 67'(m4_y_reg) * 67'(m4_td_reg);
            m5_xtd_reg <= 67'(m4_x_reg) * 67'(m4_td_reg);
            m5_wct_reg <= 70'(m4_w_reg) * 70'(m4_ct_reg);
            m5_wst_reg <= 70'(m4_w_reg) * 70'(m4_st_reg);
            m5_x_reg   <= m4_x_reg;
            m5_y_reg   <= m4_y_reg;
            m5_z_reg   <= m4_z_reg;
            m5_vz_reg  <= m4_vz_reg;
        end
    end

    // Final combine and saturate
    result_t            res_next;
    logic signed [71:0] vx_full, vy_full;

    always_comb begin
        vx_full = -rnd_shr(72'(m5_ytd_reg), 28) - rnd_shr(72'(m5_wct_reg), 30);
        vy_full = rnd_shr(72'(m5_xtd_reg), 28) - rnd_shr(72'(m5_wst_reg), 30);
        res_next.pos_x = sat32(72'(m5_x_reg));
        res_next.pos_y = sat32(72'(m5_y_reg));
        res_next.pos_z = sat32(72'(m5_z_reg));
        res_next.vel_x = sat48(vx_full);
        res_next.vel_y = sat48(vy_full);
        res_next.vel_z = sat48(72'(m5_vz_reg));
    end

    // Output register with a one-entry skid buffer
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    arrive;

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign arrive  = en && m5v_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CORDIC_N; k++) cv_reg[k] <= 1'b0;
            tv_reg  <= 1'b0;
            m1v_reg <= 1'b0;
            m2v_reg <= 1'b0;
            m3v_reg <= 1'b0;
            m4v_reg <= 1'b0;
            m5v_reg <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= s_valid;
            for (int k = 1; k <= CORDIC_N; k++) cv_reg[k] <= cv_reg[k-1];
            tv_reg  <= cv_reg[CORDIC_N];
            m1v_reg <= tv_reg;
            m2v_reg <= m1v_reg;
            m3v_reg <= m2v_reg;
            m4v_reg <= m3v_reg;
            m5v_reg <= m4v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_ready) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (arrive) begin
                if (out_valid_reg && !m_ready) begin
                    skid_reg       <= res_next;
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pos_x = out_reg.pos_x;
    assign m_pos_y = out_reg.pos_y;
    assign m_pos_z = out_reg.pos_z;
    assign m_vel_x = out_reg.vel_x;
    assign m_vel_y = out_reg.vel_y;
    assign m_vel_z = out_reg.vel_z;

endmodule

`default_nettype wire

// ===== test/tb_spherical_to_cartesian_pos_vel.sv =====
`timescale 1ns / 1ps

module tb_spherical_to_cartesian_pos_vel;
    import s2c_pkg::*;

    localparam int CLK_LIMIT   = 300000;
    localparam int LATENCY     = 38;
    localparam int ATAN_STEPS  = 30;
    localparam longint GAIN_X0 = 64'sd652032874;
    localparam longint UNIT    = 64'sd1073741824;
    localparam longint PI_BAM  = 64'sd2147483648;
    localparam longint HALF_PI = 64'sd1073741824;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_longitude;
    logic signed [31:0] s_latitude;
    logic signed [31:0] s_radius;
    logic signed [31:0] s_longitude_rate;
    logic signed [31:0] s_latitude_rate;
    logic signed [31:0] s_radius_rate;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic signed [47:0] m_vel_x;
    logic signed [47:0] m_vel_y;
    logic signed [47:0] m_vel_z;

    result_t expected_results[$];
    int      errors;
    int      sent_count;
    int      checked_count;
    int      cycle_count = 0;

    spherical_to_cartesian_pos_vel dut (.*);

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Arctangent of 2^-i in binary-angle units
    function automatic longint atan_bam(input int i);
        longint t [ATAN_STEPS] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
            'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
            'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
            'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
            'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
            'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
        };
        return t[i];
    endfunction

    // Fold into the right half plane, rotate, then clamp to +-1.0
    function automatic void rotate_angle(input longint ang, output longint sn,
                                         output longint cs);
        longint cx;
        longint cy;
        longint cz;
        longint dx;
        longint dy;
        bit     flip;
        cx = GAIN_X0;
        cy = 0;
        cz = ang;
        flip = 1'b0;
        if (cz > HALF_PI) begin
            cz -= PI_BAM;
            flip = 1'b1;
        end else if (cz < -HALF_PI) begin
            cz += PI_BAM;
            flip = 1'b1;
        end
        for (int i = 0; i < ATAN_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx;
                cy += dy;
                cz -= atan_bam(i);
            end else begin
                cx += dx;
                cy -= dy;
                cz += atan_bam(i);
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        cs = cx > UNIT ? UNIT : (cx < -UNIT ? -UNIT : cx);
        sn = cy > UNIT ? UNIT : (cy < -UNIT ? -UNIT : cy);
    endfunction

    // Exact product, round half up, then shift
    function automatic longint prod_round(input longint a, input longint b, input int s);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        p = (p + (128'sd1 <<< (s - 1))) >>> s;
        return longint'(p);
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] clip48(input longint v);
        if (v > 64'sd140737488355327) return 48'sh7FFFFFFFFFFF;
        if (v < -64'sd140737488355328) return 48'sh800000000000;
        return v[47:0];
    endfunction

    // Cartesian position and velocity of one spherical record
    function automatic result_t to_cartesian(input logic signed [31:0] lon,
                                             input logic signed [31:0] lat,
                                             input logic signed [31:0] r,
                                             input logic signed [31:0] lon_rt,
                                             input logic signed [31:0] lat_rt,
                                             input logic signed [31:0] r_rt);
        result_t res;
        longint  sl, cl, sp, cp, rcp, px, py, pz, rpd, w, vx, vy, vz;
        rotate_angle(longint'(lon), sl, cl);
        rotate_angle(longint'(lat), sp, cp);
        rcp = prod_round(r, cp, 30);
        px  = prod_round(rcp, cl, 30);
        py  = prod_round(rcp, sl, 30);
        pz  = prod_round(r, sp, 30);
        rpd = prod_round(r, lat_rt, 28);
        w   = prod_round(rpd, sp, 30) - prod_round(cp, r_rt, 30);
        vx  = -prod_round(py, lon_rt, 28) - prod_round(w, cl, 30);
        vy  = prod_round(px, lon_rt, 28) - prod_round(w, sl, 30);
        vz  = prod_round(rpd, cp, 30) + prod_round(sp, r_rt, 30);
        res.pos_x = clip32(px);
        res.pos_y = clip32(py);
        res.pos_z = clip32(pz);
        res.vel_x = clip48(vx);
        res.vel_y = clip48(vy);
        res.vel_z = clip48(vz);
        return res;
    endfunction

    // Offer one transaction at the current edge and hold until accepted
    task automatic send_record(input logic [31:0] lon, input logic [31:0] lat,
                               input logic [31:0] r, input logic [31:0] lon_rt,
                               input logic [31:0] lat_rt, input logic [31:0] r_rt);
        s_valid          <= 1'b1;
        s_longitude      <= lon;
        s_latitude       <= lat;
        s_radius         <= r;
        s_longitude_rate <= lon_rt;
        s_latitude_rate  <= lat_rt;
        s_radius_rate    <= r_rt;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(to_cartesian(lon, lat, r, lon_rt, lat_rt, r_rt));
        sent_count++;
    endtask

    // Drop valid and wait a number of cycles
    task automatic idle_cycles(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h40000000;
            2: return 32'hC0000000;
            3: return 32'h40000000 + $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0003FFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic do_reset();
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_longitude      <= '0;
        s_latitude       <= '0;
        s_radius         <= '0;
        s_longitude_rate <= '0;
        s_latitude_rate  <= '0;
        s_radius_rate    <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // Field extremes, quarter and half turns, saturation corners
    task automatic test_directed();
        send_record(0, 0, 32'h00010000, 0, 0, 0);
        send_record(32'h80000000, 0, 32'h00010000, 0, 0, 0);
        send_record(0, 32'h80000000, 32'h00010000, 0, 0, 0);
        send_record(32'h40000000, 32'h40000000, 32'h00010000, 0, 0, 0);
        send_record(32'hC0000000, 32'hC0000000, 32'h00010000, 0, 0, 0);
        send_record(32'h40000001, 32'hBFFFFFFF, 32'h00020000, 0, 0, 0);
        send_record(0, 0, 32'h80000000, 0, 0, 0);
        send_record(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        send_record(0, 32'h40000000, 32'h80000000, 0, 0, 0);
        send_record(32'h40000000, 0, 32'h80000000, 0, 0, 0);
        send_record(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_record(0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_record(32'h20000000, 32'h20000000, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF);
        send_record(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000);
        send_record(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF);
        send_record(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                    32'h55555555, 32'hAAAAAAAA);
        send_record(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                    32'hAAAAAAAA, 32'h55555555);
        send_record(32'h12345678, 32'hF0000000, 32'h00640000, 32'h10000000,
                    32'hF0000000, 32'h00010000);
        idle_cycles(1);
    endtask

    // Random records sent in bursts with random gaps
    task automatic test_random_bursts(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && count > 0; k++, count--)
                send_record(pick_angle(), pick_angle(), pick_value(), pick_value(),
                            pick_value(), pick_value());
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);
    endtask

    // Hold the sender until the pipeline is empty, then resume
    task automatic test_drain_pause();
        wait_drained();
        test_random_bursts(40);
    endtask

    // Receiver ready pattern: open, random, or mostly stalled windows
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                checked_count++;
                if (m_pos_x !== exp_r.pos_x) begin
                    $display("%0t: pos_x exp %0d got %0d", $time, exp_r.pos_x, m_pos_x);
                    errors++;
                end
                if (m_pos_y !== exp_r.pos_y) begin
                    $display("%0t: pos_y exp %0d got %0d", $time, exp_r.pos_y, m_pos_y);
                    errors++;
                end
                if (m_pos_z !== exp_r.pos_z) begin
                    $display("%0t: pos_z exp %0d got %0d", $time, exp_r.pos_z, m_pos_z);
                    errors++;
                end
                if (m_vel_x !== exp_r.vel_x) begin
                    $display("%0t: vel_x exp %0d got %0d", $time, exp_r.vel_x, m_vel_x);
                    errors++;
                end
                if (m_vel_y !== exp_r.vel_y) begin
                    $display("%0t: vel_y exp %0d got %0d", $time, exp_r.vel_y, m_vel_y);
                    errors++;
                end
                if (m_vel_z !== exp_r.vel_z) begin
                    $display("%0t: vel_z exp %0d got %0d", $time, exp_r.vel_z, m_vel_z);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CLK_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        errors        = 0;
        sent_count    = 0;
        checked_count = 0;
        do_reset();
        test_directed();
        test_random_bursts(200);
        test_drain_pause();
        test_random_bursts(200);
        wait_drained();
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Converted %0d records (angle folds, saturation, random bursts)", sent_count);
        $display("with receiver stalls; %0d results compared, %0d mismatches",
                 checked_count, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
